[design/gpcl_pkg.sv]
// ----------------------------------------------------------------------------
// gpcl_pkg
// shared types and codes of the gpio port register block
// ----------------------------------------------------------------------------
package gpcl_pkg;

    localparam int unsigned PORT_PINS   = 16;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned KEY_BIT_POS = 16;

    localparam logic [WORD_W-1:0] MODE_RESET = 32'h4444_4444;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [2:0] SEL_CFG_LOW  = 3'd0;
    localparam logic [2:0] SEL_CFG_HIGH = 3'd1;
    localparam logic [2:0] SEL_IN_DATA  = 3'd2;
    localparam logic [2:0] SEL_OUT_DATA = 3'd3;
    localparam logic [2:0] SEL_SET_RST  = 3'd4;
    localparam logic [2:0] SEL_RST      = 3'd5;
    localparam logic [2:0] SEL_LOCK     = 3'd6;
    localparam logic [2:0] SEL_UNUSED   = 3'd7;

    localparam logic [1:0] KEY_IDLE  = 2'd0;
    localparam logic [1:0] KEY_STEP1 = 2'd1;
    localparam logic [1:0] KEY_STEP2 = 2'd2;
    localparam logic [1:0] KEY_STEP3 = 2'd3;

    typedef struct packed {
        logic                   func;
        logic [2:0]             reg_sel;
        logic [WORD_W-1:0]      write_data;
        logic [PORT_PINS-1:0]   pad_levels;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0]      read_data;
        logic [PORT_PINS-1:0]   drive_levels;
        logic [WORD_W-1:0]      pin_modes_low;
        logic [WORD_W-1:0]      pin_modes_high;
        logic                   lock_active;
    } t_result;

    typedef struct packed {
        logic       lock_key;
        logic [1:0] key_step;
    } t_lock_status;

endpackage

[design/gpcl_in_stage.sv]
// ----------------------------------------------------------------------------
// gpcl_in_stage
// input register holding one bus access until the core takes it
// ----------------------------------------------------------------------------
module gpcl_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gpcl_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_ready,
    output logic            o_valid,
    output gpcl_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    gpcl_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[design/gpcl_core.sv]
// ----------------------------------------------------------------------------
// gpcl_core
// port registers, lock key sequencer and read mux
// ----------------------------------------------------------------------------
module gpcl_core #(
    parameter int unsigned PIN_COUNT = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  gpcl_pkg::t_item        i_item,
    output gpcl_pkg::t_result      o_result,
    output gpcl_pkg::t_lock_status o_status
);

    localparam int unsigned P = gpcl_pkg::PORT_PINS;
    localparam int unsigned W = gpcl_pkg::WORD_W;

    logic [P-1:0] w_pin_mask;
    logic [W-1:0] w_exist_low;
    logic [W-1:0] w_exist_high;
    logic [W-1:0] w_wr_low;
    logic [W-1:0] w_wr_high;
    logic [P-1:0] w_frozen;

    logic [W-1:0] r_mode_low,  n_mode_low;
    logic [W-1:0] r_mode_high, n_mode_high;
    logic [P-1:0] r_out_bits,  n_out_bits;
    logic [P-1:0] r_lock_bits, n_lock_bits;
    logic         r_lock_key,  n_lock_key;
    logic [1:0]   r_key_step,  n_key_step;
    logic [W-1:0] w_rd;

    logic [P-1:0] w_wbits;
    logic [P-1:0] w_wclr;
    logic [P-1:0] w_pads;
    logic         w_key;
    logic         w_same;

    genvar g;
    generate
        for (g = 0; g < P; g++) begin : g_pin
            assign w_pin_mask[g] = (g < PIN_COUNT);
        end
        for (g = 0; g < P/2; g++) begin : g_nib
            assign w_exist_low[4*g +: 4]  = {4{w_pin_mask[g]}};
            assign w_exist_high[4*g +: 4] = {4{w_pin_mask[g + P/2]}};
            assign w_wr_low[4*g +: 4]     = {4{w_pin_mask[g] & ~w_frozen[g]}};
            assign w_wr_high[4*g +: 4]    = {4{w_pin_mask[g + P/2] & ~w_frozen[g + P/2]}};
        end
    endgenerate

    assign w_frozen = r_lock_key ? r_lock_bits : '0;
    assign w_wbits  = i_item.write_data[P-1:0] & w_pin_mask;
    assign w_wclr   = i_item.write_data[W-1:P] & w_pin_mask;
    assign w_pads   = i_item.pad_levels & w_pin_mask;
    assign w_key    = i_item.write_data[gpcl_pkg::KEY_BIT_POS];
    assign w_same   = (w_wbits == r_lock_bits);

    always_comb begin
        n_mode_low  = r_mode_low;
        n_mode_high = r_mode_high;
        n_out_bits  = r_out_bits;
        n_lock_bits = r_lock_bits;
        n_lock_key  = r_lock_key;
        n_key_step  = r_key_step;
        w_rd        = '0;
        if (i_item.func == gpcl_pkg::FUNC_READ) begin
            unique case (i_item.reg_sel)
                gpcl_pkg::SEL_CFG_LOW:  w_rd = r_mode_low;
                gpcl_pkg::SEL_CFG_HIGH: w_rd = r_mode_high;
                gpcl_pkg::SEL_IN_DATA:  w_rd = {{(W-P){1'b0}}, w_pads};
                gpcl_pkg::SEL_OUT_DATA: w_rd = {{(W-P){1'b0}}, r_out_bits};
                gpcl_pkg::SEL_LOCK: begin
                    w_rd = {{(W-P-1){1'b0}}, r_lock_key, r_lock_bits};
                    if (!r_lock_key && r_key_step == gpcl_pkg::KEY_STEP3) begin
                        n_lock_key = 1'b1;
                    end
                    n_key_step = gpcl_pkg::KEY_IDLE;
                end
                default: w_rd = '0;
            endcase
        end else begin
            unique case (i_item.reg_sel)
                gpcl_pkg::SEL_CFG_LOW:
                    n_mode_low = (r_mode_low & ~w_wr_low) | (i_item.write_data & w_wr_low);
                gpcl_pkg::SEL_CFG_HIGH:
                    n_mode_high = (r_mode_high & ~w_wr_high) | (i_item.write_data & w_wr_high);
                gpcl_pkg::SEL_OUT_DATA: n_out_bits = w_wbits;
                gpcl_pkg::SEL_SET_RST:  n_out_bits = (r_out_bits & ~w_wclr) | w_wbits;
                gpcl_pkg::SEL_RST:      n_out_bits = r_out_bits & ~w_wbits;
                gpcl_pkg::SEL_LOCK: begin
                    if (!r_lock_key) begin
                        n_lock_bits = w_wbits;
                        if (w_key) begin
                            n_key_step = (r_key_step == gpcl_pkg::KEY_STEP2 && w_same)
                                       ? gpcl_pkg::KEY_STEP3 : gpcl_pkg::KEY_STEP1;
                        end else begin
                            n_key_step = (r_key_step == gpcl_pkg::KEY_STEP1 && w_same)
                                       ? gpcl_pkg::KEY_STEP2 : gpcl_pkg::KEY_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_low  <= gpcl_pkg::MODE_RESET & w_exist_low;
            r_mode_high <= gpcl_pkg::MODE_RESET & w_exist_high;
            r_out_bits  <= '0;
            r_lock_bits <= '0;
            r_lock_key  <= 1'b0;
            r_key_step  <= gpcl_pkg::KEY_IDLE;
        end else if (i_en) begin
            r_mode_low  <= n_mode_low;
            r_mode_high <= n_mode_high;
            r_out_bits  <= n_out_bits;
            r_lock_bits <= n_lock_bits;
            r_lock_key  <= n_lock_key;
            r_key_step  <= n_key_step;
        end
    end

    assign o_result.read_data      = w_rd;
    assign o_result.drive_levels   = n_out_bits;
    assign o_result.pin_modes_low  = n_mode_low;
    assign o_result.pin_modes_high = n_mode_high;
    assign o_result.lock_active    = n_lock_key;

    assign o_status.lock_key = r_lock_key;
    assign o_status.key_step = r_key_step;

endmodule

[design/gpcl_out_stage.sv]
// ----------------------------------------------------------------------------
// gpcl_out_stage
// result register holding one item until the receiver takes it
// ----------------------------------------------------------------------------
module gpcl_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  gpcl_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output gpcl_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    gpcl_pkg::t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[design/gpio_port_with_config_lock_top.sv]
// ----------------------------------------------------------------------------
// gpio_port_with_config_lock_top
// 16-pin gpio port register block with bit set/reset and a lock key
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_ready carry one bus access per item
//   (i_func, i_reg_sel, i_write_data, i_pad_levels)
//   output channel: o_valid / i_ready carry one result item per access
//   (read data plus the port state after the access)
//   an item is registered on entry, then processed by the register core
//   into the result register once that register is free
//   throughput is one item per cycle while the receiver does not stall;
//   the core register update is the only processing step
//   when the receiver stalls, the result register holds and the input
//   register holds one more item; o_ready drops once both are full
//   reset (synchronous, active low) empties both stages, sets the mode
//   nibbles of present pins to floating inputs, clears output, lock bits and the key
//   the lock key stays set until the next reset
// ----------------------------------------------------------------------------
module gpio_port_with_config_lock_top #(
    parameter int unsigned PIN_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [2:0]  i_reg_sel,
    input  logic [31:0] i_write_data,
    input  logic [15:0] i_pad_levels,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic [15:0] o_drive_levels,
    output logic [31:0] o_pin_modes_low,
    output logic [31:0] o_pin_modes_high,
    output logic        o_lock_active
);

    gpcl_pkg::t_item        w_in_item;
    gpcl_pkg::t_item        w_item;
    gpcl_pkg::t_result      w_core_result;
    gpcl_pkg::t_result      w_out_result;
    gpcl_pkg::t_lock_status w_status;
    logic                   w_item_valid;
    logic                   w_out_free;
    logic                   w_adv;

    assign w_in_item.func       = i_func;
    assign w_in_item.reg_sel    = i_reg_sel;
    assign w_in_item.write_data = i_write_data;
    assign w_in_item.pad_levels = i_pad_levels;

    assign w_adv = w_item_valid && w_out_free;

    gpcl_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (w_in_item),
        .i_advance (w_adv),
        .o_ready   (o_ready),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    gpcl_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_item   (w_item),
        .o_result (w_core_result),
        .o_status (w_status)
    );

    gpcl_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv),
        .i_result (w_core_result),
        .i_ready  (i_ready),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .o_result (w_out_result)
    );

    assign o_read_data      = w_out_result.read_data;
    assign o_drive_levels   = w_out_result.drive_levels;
    assign o_pin_modes_low  = w_out_result.pin_modes_low;
    assign o_pin_modes_high = w_out_result.pin_modes_high;
    assign o_lock_active    = w_out_result.lock_active;

    a_key_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.lock_key |=> w_status.lock_key)
        else $error("lock key cleared without reset");

    a_key_seq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.lock_key |-> (w_status.key_step == gpcl_pkg::KEY_IDLE))
        else $error("key sequence active while key is set");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !w_adv)
        else $error("core advanced into a stalled result register");

    a_key_by_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_status.lock_key) |-> $past(w_adv && w_item.func == gpcl_pkg::FUNC_READ
                                           && w_item.reg_sel == gpcl_pkg::SEL_LOCK))
        else $error("lock key set by something other than a lock read");

endmodule
